@@ src/rcm_pkg.sv @@
// Shared constants, codes and types of the RC channel mapper.
package rcm_pkg;

    localparam int SAMPLE_MAX = 4095;

    localparam int SMP_W     = 12;
    localparam int CH_W      = 3;
    localparam int OUT_W     = 8;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 3;
    localparam int MASK_W    = 8;

    localparam int MAX_W     = $clog2(SAMPLE_MAX + 1);
    localparam int QUO_W     = 8;
    localparam int NUM_W     = MAX_W + QUO_W;
    localparam int DIV_CELLS = QUO_W;

    localparam int CENTER_HI = (SAMPLE_MAX + 1) / 2;
    localparam int CENTER_LO = SAMPLE_MAX / 2;
    localparam int BASE_UP   = 128;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROLL_CENTER  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_CENTER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_YAW_CENTER   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT_MASK  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THR_AIRPLANE = 3'd4;

    // channel codes
    localparam logic [CH_W-1:0] CH_ROLL  = 3'd0;
    localparam logic [CH_W-1:0] CH_PITCH = 3'd1;
    localparam logic [CH_W-1:0] CH_THR   = 3'd2;
    localparam logic [CH_W-1:0] CH_YAW   = 3'd3;
    localparam logic [CH_W-1:0] CH_AUX1  = 3'd4;
    localparam logic [CH_W-1:0] CH_AUX2  = 3'd5;
    localparam logic [CH_W-1:0] CH_AUX3  = 3'd6;
    localparam logic [CH_W-1:0] CH_AUX4  = 3'd7;

    // request travelling along the divider row
    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [MAX_W-1:0] dvs;
        logic [QUO_W-1:0] quo;
        logic [OUT_W-1:0] base;
        logic             flip;
    } t_div_item;

endpackage

@@ src/rcm_front.sv @@
// Configuration registers and operand setup stage of the channel mapper.
module rcm_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rcm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rcm_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [rcm_pkg::CH_W-1:0]        i_channel,
    input  logic [rcm_pkg::SMP_W-1:0]       i_sample,
    output logic                            o_valid,
    input  logic                            i_ready,
    output rcm_pkg::t_div_item              o_item
);

    localparam int NW = rcm_pkg::NUM_W;

    logic [rcm_pkg::CFG_W-1:0]  r_roll_center;
    logic [rcm_pkg::CFG_W-1:0]  r_pitch_center;
    logic [rcm_pkg::CFG_W-1:0]  r_yaw_center;
    logic [rcm_pkg::MASK_W-1:0] r_invert_mask;
    logic                       r_thr_airplane;

    logic               r_valid;
    rcm_pkg::t_div_item r_item;
    rcm_pkg::t_div_item n_item;

    logic [NW-1:0] s_w;
    logic [NW-1:0] mid_w;
    logic [NW-1:0] diff;
    logic [NW-1:0] tdiff;
    logic          inv_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_roll_center  <= rcm_pkg::CFG_W'(rcm_pkg::CENTER_HI);
            r_pitch_center <= rcm_pkg::CFG_W'(rcm_pkg::CENTER_HI);
            r_yaw_center   <= rcm_pkg::CFG_W'(rcm_pkg::CENTER_HI);
            r_invert_mask  <= '0;
            r_thr_airplane <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rcm_pkg::REG_ROLL_CENTER:  r_roll_center  <= i_cfg_data;
                rcm_pkg::REG_PITCH_CENTER: r_pitch_center <= i_cfg_data;
                rcm_pkg::REG_YAW_CENTER:   r_yaw_center   <= i_cfg_data;
                rcm_pkg::REG_INVERT_MASK:  r_invert_mask  <= i_cfg_data[rcm_pkg::MASK_W-1:0];
                rcm_pkg::REG_THR_AIRPLANE: r_thr_airplane <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        s_w = NW'(i_sample);
        if (s_w > NW'(rcm_pkg::SAMPLE_MAX)) begin
            s_w = NW'(rcm_pkg::SAMPLE_MAX);
        end
        case (i_channel)
            rcm_pkg::CH_ROLL:  mid_w = NW'(r_roll_center);
            rcm_pkg::CH_PITCH: mid_w = NW'(r_pitch_center);
            rcm_pkg::CH_YAW:   mid_w = NW'(r_yaw_center);
            rcm_pkg::CH_THR:   mid_w = NW'(rcm_pkg::CENTER_LO);
            default:           mid_w = NW'(rcm_pkg::CENTER_HI);
        endcase
        if (mid_w > NW'(rcm_pkg::SAMPLE_MAX - 1)) begin
            mid_w = NW'(rcm_pkg::SAMPLE_MAX - 1);
        end
        inv_bit = r_invert_mask[i_channel];
        diff    = s_w - mid_w;
        tdiff   = s_w - NW'(rcm_pkg::CENTER_HI);

        // piecewise split about the centre
        n_item.quo = '0;
        if (s_w < mid_w) begin
            n_item.rem  = s_w << 7;
            n_item.dvs  = rcm_pkg::MAX_W'(mid_w);
            n_item.base = '0;
        end else begin
            n_item.rem  = (diff << 7) - diff;
            n_item.dvs  = rcm_pkg::MAX_W'(NW'(rcm_pkg::SAMPLE_MAX) - mid_w);
            n_item.base = rcm_pkg::OUT_W'(rcm_pkg::BASE_UP);
        end
        n_item.flip = !inv_bit;

        case (i_channel)
            rcm_pkg::CH_THR: begin
                n_item.flip = inv_bit;
                if (r_thr_airplane) begin
                    n_item.base = '0;
                    n_item.dvs  = rcm_pkg::MAX_W'(rcm_pkg::SAMPLE_MAX - rcm_pkg::CENTER_HI);
                    if (s_w < NW'(rcm_pkg::CENTER_HI)) begin
                        n_item.rem = '0;
                    end else begin
                        n_item.rem = (tdiff << 8) - tdiff;
                    end
                end
            end
            rcm_pkg::CH_AUX3, rcm_pkg::CH_AUX4: begin
                n_item.rem  = '0;
                n_item.dvs  = rcm_pkg::MAX_W'(1);
                n_item.base = rcm_pkg::OUT_W'(i_sample[0] ^ inv_bit);
                n_item.flip = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ src/rcm_div_cell.sv @@
// One restoring division cell: settles one quotient bit and passes the request on.
module rcm_div_cell #(
    parameter int BIT_POS = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  rcm_pkg::t_div_item i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output rcm_pkg::t_div_item o_item
);

    logic                          r_valid;
    rcm_pkg::t_div_item            r_item;
    rcm_pkg::t_div_item            n_item;
    logic [rcm_pkg::NUM_W-1:0]     trial;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        trial  = rcm_pkg::NUM_W'(i_item.dvs) << BIT_POS;
        n_item = i_item;
        if (i_item.rem >= trial) begin
            n_item.rem          = i_item.rem - trial;
            n_item.quo[BIT_POS] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ src/rcm_out.sv @@
// Output stage: adds the branch base, applies reversal and holds the result.
module rcm_out (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  rcm_pkg::t_div_item        i_item,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [rcm_pkg::OUT_W-1:0] o_value
);

    logic                      r_valid;
    logic [rcm_pkg::OUT_W-1:0] r_value;
    logic [rcm_pkg::OUT_W-1:0] n_value;
    logic [rcm_pkg::OUT_W-1:0] sum;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        sum     = rcm_pkg::OUT_W'(i_item.quo) + i_item.base;
        n_value = i_item.flip ? ~sum : sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_value <= n_value;
        end
    end

    assign o_valid = r_valid;
    assign o_value = r_value;

endmodule

@@ src/rc_channel_mapper.sv @@
// Top level of the RC channel mapper: setup stage, divider row and output stage.
//
// Input stream: tuser carries the channel number, tdata the 12-bit stick sample.
// Output stream: tdata carries the 8-bit channel value, one per request.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 roll centre, 1 pitch centre, 2 yaw centre, 3 invert mask, 4 throttle mode);
// unknown indexes are ignored. Write only while no request is in flight.
// From acceptance to o_m_axis_tvalid a request passes through one setup
// stage, eight division cells (one quotient bit each) and the output register.
// Throughput: one request per cycle while unstalled, set by the single-bit division cells.
// Each stage holds its own valid bit, so bubbles close up and new requests are
// taken while a result waits; a stalled receiver fills the row and then drops
// o_s_axis_tready. Results leave in request order.
// Reset clears all valid bits and restores the register defaults (centres 2048,
// invert mask 0, airplane throttle).
module rc_channel_mapper (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rcm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rcm_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [15:0]                       i_s_axis_tdata,   // [11:0] sample, zero pad
    input  logic [rcm_pkg::CH_W-1:0]          i_s_axis_tuser,   // [2:0] channel
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [rcm_pkg::OUT_W-1:0]         o_m_axis_tdata    // [7:0] mapped_value
);

    localparam int NC = rcm_pkg::DIV_CELLS;

    logic               stg_valid [NC+1];
    logic               stg_ready [NC+1];
    rcm_pkg::t_div_item stg_item  [NC+1];

    rcm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_channel  (i_s_axis_tuser),
        .i_sample   (i_s_axis_tdata[rcm_pkg::SMP_W-1:0]),
        .o_valid    (stg_valid[0]),
        .i_ready    (stg_ready[0]),
        .o_item     (stg_item[0])
    );

    for (genvar g = 0; g < NC; g++) begin : g_cell
        rcm_div_cell #(
            .BIT_POS (NC - 1 - g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stg_valid[g]),
            .o_ready (stg_ready[g]),
            .i_item  (stg_item[g]),
            .o_valid (stg_valid[g+1]),
            .i_ready (stg_ready[g+1]),
            .o_item  (stg_item[g+1])
        );
    end

    rcm_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (stg_valid[NC]),
        .o_ready (stg_ready[NC]),
        .i_item  (stg_item[NC]),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_value (o_m_axis_tdata)
    );

endmodule

@@ src/rcm_checker.sv @@
// Port-level checks of the RC channel mapper and their binding to the top level.
module rcm_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    input  logic                          o_s_axis_tready,
    input  logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    input  logic [rcm_pkg::OUT_W-1:0]     o_m_axis_tdata
);

    logic acc;
    assign acc = i_s_axis_tvalid && o_s_axis_tready;

    a_rst_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid || i_m_axis_tready |-> o_s_axis_tready)
        else $error("input stalled with free output stage");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc ##1 i_m_axis_tready ##1 i_m_axis_tready ##1 i_m_axis_tready
            ##1 i_m_axis_tready ##1 i_m_axis_tready ##1 i_m_axis_tready
            ##1 i_m_axis_tready ##1 i_m_axis_tready ##1 i_m_axis_tready
        |=> o_m_axis_tvalid)
        else $error("result late with receiver ready");

endmodule

bind rc_channel_mapper rcm_checker u_rcm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

@@ tb/rc_channel_mapper_tb.sv @@
// Self-checking testbench for the RC channel mapper: directed table, then randomised phases.
`timescale 1ns / 100ps

module rc_channel_mapper_tb;

    localparam int CLK_HALF        = 4;
    localparam int RESET_CYCLES    = 5;
    localparam int DIR_N           = 23;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 228;
    localparam int TAIL_CYCLES     = 20;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int IDX_TOP         = (1 << rcm_pkg::CFG_IDX_W) - 1;

    typedef struct packed {
        logic [rcm_pkg::CH_W-1:0]  ch;
        logic [rcm_pkg::SMP_W-1:0] smp;
        logic                      typed;
        logic [rcm_pkg::OUT_W-1:0] value;
    } t_stim_row;

    typedef struct packed {
        logic [rcm_pkg::CFG_W-1:0] roll;
        logic [rcm_pkg::CFG_W-1:0] pitch;
        logic [rcm_pkg::CFG_W-1:0] yaw;
        logic [rcm_pkg::CFG_W-1:0] mask;
        logic [rcm_pkg::CFG_W-1:0] mode;
    } t_setting;

    logic                          i_clk           = 1'b0;
    logic                          i_rst_n         = 1'b0;
    logic                          i_cfg_we        = 1'b0;
    logic [rcm_pkg::CFG_IDX_W-1:0] i_cfg_idx       = '0;
    logic [rcm_pkg::CFG_W-1:0]     i_cfg_data      = '0;
    logic                          i_s_axis_tvalid = 1'b0;
    logic                          o_s_axis_tready;
    logic [15:0]                   i_s_axis_tdata  = '0;
    logic [rcm_pkg::CH_W-1:0]      i_s_axis_tuser  = '0;
    logic                          o_m_axis_tvalid;
    logic                          i_m_axis_tready = 1'b0;
    logic [rcm_pkg::OUT_W-1:0]     o_m_axis_tdata;

    // local copy of the register file
    logic [rcm_pkg::CFG_W-1:0]  centre_roll       = 12'd2048;
    logic [rcm_pkg::CFG_W-1:0]  centre_pitch      = 12'd2048;
    logic [rcm_pkg::CFG_W-1:0]  centre_yaw        = 12'd2048;
    logic [rcm_pkg::MASK_W-1:0] invert_bits       = '0;
    logic                       airplane_throttle = 1'b1;

    logic [rcm_pkg::OUT_W-1:0] pending_values [$];
    int                        mismatches  = 0;
    int                        idle_cycles = 0;
    int                        ready_run   = 0;
    t_stim_row                 stim_rows [DIR_N];
    t_setting                  settings  [NUM_PHASES];

    rc_channel_mapper i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    function automatic int unsigned scale_about_centre(int unsigned smp,
                                                       int unsigned centre);
        int unsigned mid;
        int unsigned s;
        mid = (centre > rcm_pkg::SAMPLE_MAX - 1) ? rcm_pkg::SAMPLE_MAX - 1 : centre;
        s   = (smp > rcm_pkg::SAMPLE_MAX) ? rcm_pkg::SAMPLE_MAX : smp;
        if (s < mid) begin
            return s * 128 / mid;
        end
        return (s - mid) * 127 / (rcm_pkg::SAMPLE_MAX - mid) + rcm_pkg::BASE_UP;
    endfunction

    function automatic logic [rcm_pkg::OUT_W-1:0] predict_mapped(
        logic [rcm_pkg::CH_W-1:0] ch, logic [rcm_pkg::SMP_W-1:0] smp);
        int unsigned v;
        int unsigned t;
        logic        flip;
        logic        reverse;
        flip    = invert_bits[ch];
        reverse = ~flip;
        t       = (smp > rcm_pkg::SAMPLE_MAX) ? rcm_pkg::SAMPLE_MAX : smp;
        case (ch)
            rcm_pkg::CH_ROLL:  v = scale_about_centre(smp, centre_roll);
            rcm_pkg::CH_PITCH: v = scale_about_centre(smp, centre_pitch);
            rcm_pkg::CH_YAW:   v = scale_about_centre(smp, centre_yaw);
            rcm_pkg::CH_AUX1,
            rcm_pkg::CH_AUX2:  v = scale_about_centre(smp, rcm_pkg::CENTER_HI);
            rcm_pkg::CH_THR: begin
                reverse = flip;
                if (!airplane_throttle) begin
                    v = scale_about_centre(smp, rcm_pkg::CENTER_LO);
                end else if (t < rcm_pkg::CENTER_HI) begin
                    v = 0;
                end else begin
                    v = (t - rcm_pkg::CENTER_HI) * 255
                        / (rcm_pkg::SAMPLE_MAX - rcm_pkg::CENTER_HI);
                end
            end
            default: begin
                v       = smp[0] ^ flip;
                reverse = 1'b0;
            end
        endcase
        return reverse ? rcm_pkg::OUT_W'(255 - v) : rcm_pkg::OUT_W'(v);
    endfunction

    task automatic write_reg(input logic [rcm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rcm_pkg::CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            rcm_pkg::REG_ROLL_CENTER:  centre_roll       = data;
            rcm_pkg::REG_PITCH_CENTER: centre_pitch      = data;
            rcm_pkg::REG_YAW_CENTER:   centre_yaw        = data;
            rcm_pkg::REG_INVERT_MASK:  invert_bits       = data[rcm_pkg::MASK_W-1:0];
            rcm_pkg::REG_THR_AIRPLANE: airplane_throttle = data[0];
            default: ;
        endcase
    endtask

    task automatic send_request(input logic [rcm_pkg::CH_W-1:0] ch,
                                input logic [rcm_pkg::SMP_W-1:0] smp,
                                input logic typed, input logic [rcm_pkg::OUT_W-1:0] value);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {4'b0, smp};
        i_s_axis_tuser  <= ch;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_values.push_back(typed ? value : predict_mapped(ch, smp));
    endtask

    task automatic drain_results();
        while (pending_values.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [rcm_pkg::CFG_W-1:0] random_centre();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 12'd4094;
            2:       return 12'd4095;
            default: return rcm_pkg::CFG_W'($urandom_range(0, 4095));
        endcase
    endfunction

    // receiver: ready and stall runs of random length, with long fully-ready stretches
    always @(posedge i_clk) begin
        if (ready_run == 0) begin
            if (i_m_axis_tready) begin
                i_m_axis_tready <= 1'b0;
                ready_run <= ($urandom_range(0, 15) == 0) ? $urandom_range(20, 30)
                                                         : $urandom_range(0, 5);
            end else begin
                i_m_axis_tready <= 1'b1;
                ready_run <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                        : $urandom_range(0, 20);
            end
        end else begin
            ready_run <= ready_run - 1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_values.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual %0d",
                         $time, o_m_axis_tdata);
            end else if (pending_values[0] !== o_m_axis_tdata) begin
                mismatches++;
                $display("%0t: mapped_value mismatch, expected %0d, actual %0d",
                         $time, pending_values.pop_front(), o_m_axis_tdata);
            end else begin
                void'(pending_values.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        int                        sent;
        int                        burst;
        int                        gap;
        int                        gap_max;
        logic [rcm_pkg::CH_W-1:0]  ch;
        logic [rcm_pkg::SMP_W-1:0] smp;
        int unsigned               centre;

        stim_rows = '{
            '{rcm_pkg::CH_ROLL,  12'd0,    1'b1, 8'd255},
            '{rcm_pkg::CH_ROLL,  12'd4095, 1'b1, 8'd0},
            '{rcm_pkg::CH_ROLL,  12'd2048, 1'b1, 8'd127},
            '{rcm_pkg::CH_ROLL,  12'd2047, 1'b0, 8'd0},
            '{rcm_pkg::CH_PITCH, 12'd0,    1'b1, 8'd255},
            '{rcm_pkg::CH_PITCH, 12'd4095, 1'b1, 8'd0},
            '{rcm_pkg::CH_THR,   12'd0,    1'b1, 8'd0},
            '{rcm_pkg::CH_THR,   12'd2047, 1'b1, 8'd0},
            '{rcm_pkg::CH_THR,   12'd2048, 1'b1, 8'd0},
            '{rcm_pkg::CH_THR,   12'd4095, 1'b1, 8'd255},
            '{rcm_pkg::CH_THR,   12'd3000, 1'b0, 8'd0},
            '{rcm_pkg::CH_YAW,   12'd0,    1'b1, 8'd255},
            '{rcm_pkg::CH_YAW,   12'd4095, 1'b1, 8'd0},
            '{rcm_pkg::CH_AUX1,  12'd0,    1'b1, 8'd255},
            '{rcm_pkg::CH_AUX1,  12'd4095, 1'b1, 8'd0},
            '{rcm_pkg::CH_AUX1,  12'd2048, 1'b1, 8'd127},
            '{rcm_pkg::CH_AUX2,  12'd1000, 1'b0, 8'd0},
            '{rcm_pkg::CH_AUX2,  12'd4095, 1'b1, 8'd0},
            '{rcm_pkg::CH_AUX3,  12'd0,    1'b1, 8'd0},
            '{rcm_pkg::CH_AUX3,  12'd1,    1'b1, 8'd1},
            '{rcm_pkg::CH_AUX3,  12'd4094, 1'b1, 8'd0},
            '{rcm_pkg::CH_AUX4,  12'd4095, 1'b1, 8'd1},
            '{rcm_pkg::CH_AUX4,  12'd2,    1'b1, 8'd0}
        };

        // centre zero, out-of-range centre, full inversion, centred throttle first
        settings[0] = '{12'd0,    12'd4095, 12'd4094, 12'h0FF, 12'd0};
        settings[1] = '{12'd1,    12'd2047, 12'd4095, 12'hF00, 12'hFFF};
        settings[2] = '{12'd4094, 12'd0,    12'd2048, 12'h3A5, 12'hFFE};
        for (int p = 3; p < NUM_PHASES; p++) begin
            settings[p] = '{random_centre(), random_centre(), random_centre(),
                            rcm_pkg::CFG_W'($urandom_range(0, 4095)),
                            rcm_pkg::CFG_W'($urandom_range(0, 4095))};
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_N; r++) begin
            send_request(stim_rows[r].ch, stim_rows[r].smp, stim_rows[r].typed,
                         stim_rows[r].value);
        end
        i_s_axis_tvalid <= 1'b0;
        drain_results();

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_reg(rcm_pkg::REG_ROLL_CENTER,  settings[p].roll);
            write_reg(rcm_pkg::REG_PITCH_CENTER, settings[p].pitch);
            write_reg(rcm_pkg::REG_YAW_CENTER,   settings[p].yaw);
            write_reg(rcm_pkg::REG_INVERT_MASK,  settings[p].mask);
            write_reg(rcm_pkg::REG_THR_AIRPLANE, settings[p].mode);
            write_reg(rcm_pkg::CFG_IDX_W'($urandom_range(rcm_pkg::REG_THR_AIRPLANE + 1,
                                                         IDX_TOP)),
                      rcm_pkg::CFG_W'($urandom));
            i_cfg_we <= 1'b0;

            case (p % 3)
                0:       gap_max = 0;
                1:       gap_max = 3;
                default: gap_max = 12;
            endcase
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                burst = $urandom_range(1, 32);
                for (int k = 0; k < burst && sent < ITEMS_PER_PHASE; k++) begin
                    ch = rcm_pkg::CH_W'($urandom_range(0, IDX_TOP));
                    case (ch)
                        rcm_pkg::CH_ROLL:  centre = centre_roll;
                        rcm_pkg::CH_PITCH: centre = centre_pitch;
                        rcm_pkg::CH_YAW:   centre = centre_yaw;
                        rcm_pkg::CH_THR:   centre = airplane_throttle ? rcm_pkg::CENTER_HI
                                                                      : rcm_pkg::CENTER_LO;
                        default:           centre = rcm_pkg::CENTER_HI;
                    endcase
                    case ($urandom_range(0, 15))
                        0:       smp = '0;
                        1:       smp = '1;
                        2:       smp = rcm_pkg::SMP_W'(centre - 1);
                        3:       smp = rcm_pkg::SMP_W'(centre);
                        4:       smp = rcm_pkg::SMP_W'(centre + 1);
                        default: smp = rcm_pkg::SMP_W'($urandom_range(0, 4095));
                    endcase
                    send_request(ch, smp, 1'b0, '0);
                    sent++;
                end
                if ($urandom_range(0, 39) == 0) begin
                    i_s_axis_tvalid <= 1'b0;
                    drain_results();
                end else if (gap_max != 0) begin
                    gap = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(0, gap_max);
                    if (gap != 0) begin
                        i_s_axis_tvalid <= 1'b0;
                        repeat (gap) @(posedge i_clk);
                    end
                end
            end
            i_s_axis_tvalid <= 1'b0;
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_values.size() != 0) begin
            mismatches++;
            $display("%0t: results missing, expected %0d more, actual 0",
                     $time, pending_values.size());
        end
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
